// File: rtl/core/lsfc_pkg.sv
package lsfc_pkg;

    localparam int ROWS      = 12;
    localparam int PLANES    = 3;
    localparam int ROW_BYTES = 6;
    localparam int LEVELS    = 256;

    localparam int ROW_W   = 4;
    localparam int PLANE_W = 2;
    localparam int LEVEL_W = 8;
    localparam int HOLD_W  = 8;
    localparam int OFF_W   = 8;
    localparam int LINE_W  = 5;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [LEVEL_W-1:0] TIMEOUT_OFF = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(LEVELS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(ROWS - 1);
    localparam logic [PLANE_W-1:0] PLANE_LAST  = PLANE_W'(PLANES - 1);
    localparam int                 PLANE_BYTES = ROWS * ROW_BYTES;

    typedef enum logic [1:0] {
        ACT_REFRESH = 2'd0,
        ACT_SWAP    = 2'd1,
        ACT_BRIGHT  = 2'd2,
        ACT_IDLE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        FADE_NONE = 2'd0,
        FADE_OUT  = 2'd1,
        FADE_IN   = 2'd2
    } fade_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT    = 3'd0,
        CFG_FADE_IDLE  = 3'd1,
        CFG_END_ACTION = 3'd2,
        CFG_HOLD_LOW   = 3'd3,
        CFG_HOLD_MID   = 3'd4,
        CFG_HOLD_HIGH  = 3'd5
    } cfg_index_t;

    // dithered row order, rows beyond the table map to themselves
    function automatic logic [ROW_W-1:0] dither_row(input logic [ROW_W-1:0] row);
        logic [ROW_W-1:0] y;
        unique case (row)
            4'd0:    y = 4'd7;
            4'd1:    y = 4'd2;
            4'd2:    y = 4'd9;
            4'd3:    y = 4'd0;
            4'd4:    y = 4'd11;
            4'd5:    y = 4'd4;
            4'd6:    y = 4'd6;
            4'd7:    y = 4'd8;
            4'd8:    y = 4'd1;
            4'd9:    y = 4'd10;
            4'd10:   y = 4'd3;
            4'd11:   y = 4'd5;
            default: y = row;
        endcase
        return y;
    endfunction

    // driver line swizzle, selects beyond the table pass through
    function automatic logic [LINE_W-1:0] swizzle_line(input logic [LINE_W-1:0] sel);
        logic [LINE_W-1:0] l;
        unique case (sel)
            5'd0:    l = 5'd11;
            5'd1:    l = 5'd7;
            5'd2:    l = 5'd10;
            5'd3:    l = 5'd6;
            5'd4:    l = 5'd9;
            5'd5:    l = 5'd5;
            5'd6:    l = 5'd8;
            5'd7:    l = 5'd4;
            5'd8:    l = 5'd23;
            5'd9:    l = 5'd3;
            5'd10:   l = 5'd22;
            5'd11:   l = 5'd2;
            5'd12:   l = 5'd21;
            5'd13:   l = 5'd1;
            5'd14:   l = 5'd20;
            5'd15:   l = 5'd0;
            5'd16:   l = 5'd19;
            5'd17:   l = 5'd15;
            5'd18:   l = 5'd18;
            5'd19:   l = 5'd14;
            5'd20:   l = 5'd17;
            5'd21:   l = 5'd13;
            5'd22:   l = 5'd16;
            5'd23:   l = 5'd12;
            default: l = sel;
        endcase
        return l;
    endfunction

endpackage

// File: rtl/core/led_scan_fade_controller_top.sv
// channel  | valid/ready         | tdata (low bit up)                            | side
// ---------+---------------------+-----------------------------------------------+--------------
// input    | s_tvalid/s_tready   | new_brightness[7:0], anim_running[8], 0 pad   | tuser action
// result   | m_tvalid/m_tready   | front, row, half, plane, offset, line, pwm,   | tlast frame
//          |                     | end_action, swap_pending (32 bits)            | end
// config   | cfg_wr_en           | cfg_index, cfg_data                           |
//
// one result per item; the result is registered and appears in the cycle after the item is accepted
// a new item can be taken every cycle while no result is stalled, the scan/fade update is combinational logic
// aresetn is synchronous, active low, and restores all counters and registers except the m_tdata/m_tlast registers
// a stalled result holds in the output register and s_tready drops until taken
module led_scan_fade_controller_top
    import lsfc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // new_brightness, anim_running
    input  logic [ACT_W-1:0]      s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // front_select, scan_row, half_select, plane_index, segment_offset,
    // drive_line, pwm_level, end_action, swap_pending
    output logic [31:0]           m_tdata,
    output logic                  m_tlast,   // frame_end
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [7:0]         timeout_limit_reg;
    logic               fade_on_idle_reg;
    logic [1:0]         idle_end_action_reg;
    logic [HOLD_W-1:0]  hold_low_reg, hold_mid_reg, hold_high_reg;

    logic [ROW_W-1:0]   row_count_reg, row_count_next;
    logic               half_count_reg, half_count_next;
    logic [PLANE_W-1:0] plane_count_reg, plane_count_next;
    logic [HOLD_W-1:0]  hold_count_reg, hold_count_next;
    logic               front_buf_reg, front_buf_next;
    logic               swap_req_reg, swap_req_next;
    logic               bright_req_reg, bright_req_next;
    logic [LEVEL_W-1:0] bright_level_reg, bright_level_next;
    logic [7:0]         idle_count_reg, idle_count_next;
    logic               idle_armed_reg, idle_armed_next;
    fade_mode_t         fade_mode_reg, fade_mode_next;
    logic [LEVEL_W-1:0] fade_level_reg, fade_level_next;
    logic [LEVEL_W-1:0] drive_level_reg, drive_level_next;

    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic               m_last_reg;

    logic               accept;
    action_t            action;
    logic [LEVEL_W-1:0] new_brightness;
    logic               anim_running;

    logic [ROW_W-1:0]   seg_row;
    logic [LINE_W-1:0]  seg_sel;
    logic [9:0]         seg_off_wide;
    logic [OFF_W-1:0]   seg_off;
    logic [1:0]         end_act;
    logic               frame_end;

    function automatic logic [HOLD_W-1:0] hold_for(
        input logic [PLANE_W-1:0] plane,
        input logic [HOLD_W-1:0]  lo,
        input logic [HOLD_W-1:0]  mid,
        input logic [HOLD_W-1:0]  hi
    );
        logic [HOLD_W-1:0] h;
        priority if (plane == 2'd0) h = lo;
        else if (plane == 2'd1)     h = mid;
        else                        h = hi;
        return h;
    endfunction

    assign s_tready       = aresetn && (!m_valid_reg || m_tready);
    assign accept         = s_tvalid && s_tready;
    assign action         = action_t'(s_tuser);
    assign new_brightness = s_tdata[7:0];
    assign anim_running   = s_tdata[8];

    // segment described by the state before the step
    assign seg_row      = dither_row(row_count_reg);
    assign seg_sel      = {seg_row, half_count_reg};
    assign seg_off_wide = 10'(plane_count_reg) * 10'(PLANE_BYTES)
                        + 10'(seg_row) * 10'(ROW_BYTES)
                        + (half_count_reg ? 10'(ROW_BYTES) : 10'(ROW_BYTES / 2));
    assign seg_off      = seg_off_wide[OFF_W-1:0];

    always_comb begin
        fade_mode_t         mode_mid;
        logic [HOLD_W-1:0]  hold_dec;

        row_count_next    = row_count_reg;
        half_count_next   = half_count_reg;
        plane_count_next  = plane_count_reg;
        hold_count_next   = hold_count_reg;
        front_buf_next    = front_buf_reg;
        swap_req_next     = swap_req_reg;
        bright_req_next   = bright_req_reg;
        bright_level_next = bright_level_reg;
        idle_count_next   = idle_count_reg;
        idle_armed_next   = idle_armed_reg;
        fade_mode_next    = fade_mode_reg;
        fade_level_next   = fade_level_reg;
        drive_level_next  = drive_level_reg;
        end_act           = 2'd0;
        frame_end         = 1'b0;
        mode_mid          = fade_mode_reg;
        hold_dec          = hold_count_reg - 8'd1;

        if (accept) begin
            unique case (action)
                ACT_REFRESH: begin
                    if (!half_count_reg) begin
                        half_count_next = 1'b1;
                        if (row_count_reg == '0) begin
                            row_count_next  = ROW_LAST;
                            hold_count_next = hold_dec;
                            if (hold_dec == '0) begin
                                if (plane_count_reg == '0) begin
                                    plane_count_next = PLANE_LAST;
                                    frame_end        = 1'b1;
                                    // frame-end sequence: swap, brightness, timeout, fade
                                    if (swap_req_reg) begin
                                        swap_req_next  = 1'b0;
                                        front_buf_next = !front_buf_reg;
                                    end
                                    if (bright_req_reg) begin
                                        bright_req_next  = 1'b0;
                                        drive_level_next = bright_level_reg;
                                        idle_count_next  = '0;
                                        fade_level_next  = '0;
                                        fade_mode_next   = FADE_NONE;
                                    end
                                    if (timeout_limit_reg < TIMEOUT_OFF
                                        && fade_mode_next == FADE_NONE
                                        && idle_armed_reg && !anim_running) begin
                                        if (idle_count_next >= timeout_limit_reg) begin
                                            if (fade_on_idle_reg) begin
                                                fade_mode_next  = FADE_OUT;
                                                fade_level_next = bright_level_reg;
                                            end else begin
                                                end_act         = idle_end_action_reg;
                                                idle_count_next = '0;
                                            end
                                            idle_armed_next = 1'b0;
                                        end else begin
                                            idle_count_next = idle_count_next + 8'd1;
                                        end
                                    end
                                    mode_mid = fade_mode_next;
                                    unique case (mode_mid)
                                        FADE_IN: begin
                                            if (fade_level_next >= bright_level_reg) begin
                                                idle_count_next = '0;
                                                fade_mode_next  = FADE_NONE;
                                            end else begin
                                                fade_level_next = fade_level_next + 8'd1;
                                            end
                                            drive_level_next = fade_level_next;
                                        end
                                        FADE_OUT: begin
                                            if (fade_level_next == '0) begin
                                                end_act        = idle_end_action_reg;
                                                fade_mode_next = FADE_IN;
                                            end else begin
                                                fade_level_next = fade_level_next - 8'd1;
                                            end
                                            drive_level_next = fade_level_next;
                                        end
                                        default: ;
                                    endcase
                                end else begin
                                    plane_count_next = plane_count_reg - 2'd1;
                                end
                                hold_count_next = hold_for(plane_count_next, hold_low_reg,
                                                           hold_mid_reg, hold_high_reg);
                            end
                        end else begin
                            row_count_next = row_count_reg - 4'd1;
                        end
                    end else begin
                        half_count_next = 1'b0;
                    end
                end
                ACT_SWAP: swap_req_next = 1'b1;
                ACT_BRIGHT: begin
                    bright_level_next = (new_brightness > LEVEL_MAX) ? LEVEL_MAX
                                                                     : new_brightness;
                    bright_req_next   = 1'b1;
                end
                ACT_IDLE: begin
                    idle_count_next = '0;
                    idle_armed_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg   <= 8'd255;
            fade_on_idle_reg    <= 1'b0;
            idle_end_action_reg <= 2'd0;
            hold_low_reg        <= 8'd1;
            hold_mid_reg        <= 8'd3;
            hold_high_reg       <= 8'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TIMEOUT:    timeout_limit_reg   <= cfg_data;
                CFG_FADE_IDLE:  fade_on_idle_reg    <= cfg_data[0];
                CFG_END_ACTION: idle_end_action_reg <= cfg_data[1:0];
                CFG_HOLD_LOW:   hold_low_reg        <= cfg_data;
                CFG_HOLD_MID:   hold_mid_reg        <= cfg_data;
                CFG_HOLD_HIGH:  hold_high_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= ROW_LAST;
            half_count_reg   <= 1'b1;
            plane_count_reg  <= PLANE_LAST;
            hold_count_reg   <= hold_for(PLANE_LAST, 8'd1, 8'd3, 8'd4);
            front_buf_reg    <= 1'b0;
            swap_req_reg     <= 1'b0;
            bright_req_reg   <= 1'b0;
            bright_level_reg <= LEVEL_W'(LEVELS / 2);
            idle_count_reg   <= '0;
            idle_armed_reg   <= 1'b0;
            fade_mode_reg    <= FADE_IN;
            fade_level_reg   <= '0;
            drive_level_reg  <= '0;
        end else begin
            row_count_reg    <= row_count_next;
            half_count_reg   <= half_count_next;
            plane_count_reg  <= plane_count_next;
            hold_count_reg   <= hold_count_next;
            front_buf_reg    <= front_buf_next;
            swap_req_reg     <= swap_req_next;
            bright_req_reg   <= bright_req_next;
            bright_level_reg <= bright_level_next;
            idle_count_reg   <= idle_count_next;
            idle_armed_reg   <= idle_armed_next;
            fade_mode_reg    <= fade_mode_next;
            fade_level_reg   <= fade_level_next;
            drive_level_reg  <= drive_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {swap_req_next, end_act, drive_level_next, swizzle_line(seg_sel),
                           seg_off, plane_count_reg, half_count_reg, seg_row, front_buf_reg};
            m_last_reg <= frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // a non-refresh item never ends a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && action != ACT_REFRESH) |=> (m_tvalid && !m_tlast && m_tdata[30:29] == 2'd0))
        else $error("non-refresh item reported frame end or action");

    // a frame ends only on the left half of the last row of plane 0
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[7:6] == 2'd0 && !m_tdata[5]))
        else $error("frame end outside last segment");

    // an end action only comes with a frame end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[30:29] != 2'd0) |-> m_tlast)
        else $error("end action without frame end");

    // every refresh item flips the half
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && action == ACT_REFRESH) |=> (half_count_reg != $past(half_count_reg)))
        else $error("half did not toggle on refresh");

endmodule
